// ----- hdl/svrd_pkg.sv -----
// Shared types, constants and constant tables for the sine voice with release decay.
package svrd_pkg;

    // Parameter defaults
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SINE_DEPTH_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Field and register widths
    localparam int OPCODE_W   = 2;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int BEND_W     = 14;
    localparam int SAMPLE_W   = 16;
    localparam int FS_W       = 18;
    localparam int OFS_W      = 7;
    localparam int GAIN_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_BEND     = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd2;

    // Register reset values
    localparam logic [FS_W-1:0]   FS_RESET   = 18'd48000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 13'd4096;

    // Arithmetic constants
    localparam logic [31:0] HALF_PI_Q30   = 32'd1686629713;
    localparam logic [31:0] AMP_RECIP     = 32'd6763728;   // floor(2^32 / 635)
    localparam logic [15:0] RELEASE_ONE   = 16'd32768;
    localparam logic [15:0] RELEASE_DECAY = 16'd64881;
    localparam logic [15:0] RELEASE_FLOOR = 16'd163;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_ON_F,
        S_ON_A,
        S_ON_B,
        S_BD_A,
        S_BD_B,
        S_BD_C,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_END,
        S_TX,
        S_TXS,
        S_KA,
        S_KB,
        S_KC,
        S_KD,
        S_TMAG,
        S_TAMP,
        S_TFULL,
        S_TOUT,
        S_TREL
    } t_state;

    // 55 * 2^(k/12) in Q30
    function automatic logic [37:0] semi55(input logic [3:0] k);
        logic [37:0] v;
        case (k)
            4'd0:    v = 38'd55 * 38'd1073741824;
            4'd1:    v = 38'd55 * 38'd1137589835;
            4'd2:    v = 38'd55 * 38'd1205234447;
            4'd3:    v = 38'd55 * 38'd1276901417;
            4'd4:    v = 38'd55 * 38'd1352829927;
            4'd5:    v = 38'd55 * 38'd1433273380;
            4'd6:    v = 38'd55 * 38'd1518500250;
            4'd7:    v = 38'd55 * 38'd1608794974;
            4'd8:    v = 38'd55 * 38'd1704458901;
            4'd9:    v = 38'd55 * 38'd1805811301;
            4'd10:   v = 38'd55 * 38'd1913190429;
            4'd11:   v = 38'd55 * 38'd2026954652;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Bend ratio points at -2..+2 semitones, Q30
    function automatic logic [31:0] bend_q30(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd0:    v = 32'd956595215;
            3'd1:    v = 32'd1013477326;
            3'd2:    v = 32'd1073741824;
            3'd3:    v = 32'd1137589835;
            3'd4:    v = 32'd1205234447;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Taylor term divisor (2k)(2k+1)
    function automatic logic [7:0] taylor_div(input logic [2:0] k);
        logic [7:0] v;
        case (k)
            3'd1:    v = 8'd6;
            3'd2:    v = 8'd20;
            3'd3:    v = 8'd42;
            3'd4:    v = 8'd72;
            3'd5:    v = 8'd110;
            3'd6:    v = 8'd156;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

    // floor(2^32 / divisor) for the Taylor terms
    function automatic logic [31:0] taylor_recip(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            3'd1:    v = 32'd715827882;
            3'd2:    v = 32'd214748364;
            3'd3:    v = 32'd102261126;
            3'd4:    v = 32'd59652323;
            3'd5:    v = 32'd39045157;
            3'd6:    v = 32'd27531841;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/svrd_in_if.sv -----
// Request channel carrying voice events into the block.
interface svrd_in_if;
    import svrd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [NOTE_W-1:0]   note_number;
    logic [VEL_W-1:0]    note_velocity;
    logic                allow_release;
    logic [BEND_W-1:0]   bend_position;

    modport source(output valid, output opcode, output note_number, output note_velocity,
                   output allow_release, output bend_position, input ready);
    modport sink(input valid, input opcode, input note_number, input note_velocity,
                 input allow_release, input bend_position, output ready);
endinterface

// ----- hdl/svrd_out_if.sv -----
// Result channel carrying one audio sample per tick out of the block.
interface svrd_out_if;
    import svrd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       voice_active;
    logic                       voice_finished;

    modport source(output valid, output sample_out, output voice_active,
                   output voice_finished, input ready);
    modport sink(input valid, input sample_out, input voice_active,
                 input voice_finished, output ready);
endinterface

// ----- hdl/sine_voice_with_release_decay_top.sv -----
// Single sine voice: phase accumulator, Taylor sine, exponential release.
//
// Usage:
//   i_in_ch carries requests: note on, note off (soft or hard), pitch wheel
//   and sample tick. Each tick returns exactly one sample on o_out_ch; the
//   other requests return nothing. i_cfg_* writes sample rate, note offset
//   and gain; writes land at the next note on and must be made while idle.
// Work per request (DW = PHASE_BITS + 17 quotient bits):
//   note off, or pitch wheel while silent: no work beyond the accept
//   tick while silent: zero sample;  tick while sounding: Taylor sine
//   note on and pitch wheel while sounding: DW-bit divide
//   A tick while sounding steps the single shared 32x32 multiplier
//   through the sine Taylor terms (three products per term, six terms). Note
//   on and pitch wheel run the restoring divider, one quotient bit a
//   cycle, that turns frequency into phase step.
// One request is in work at a time; ready is low while it runs.
// A finished sample sits in an output register; the next request is accepted
// while it waits. A tick that finds the register still full holds its result
// and stays busy until the receiver takes the old sample.
// Reset (synchronous, active low) silences the voice, clears phase and step
// and loads 48000 Hz, offset 0 and gain 1.0. SINE_TABLE_DEPTH must be a
// power of two.
module sine_voice_with_release_decay_top #(
    parameter int PHASE_BITS       = svrd_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = svrd_pkg::SINE_DEPTH_DEF,
    parameter int SAMPLE_BITS      = svrd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    svrd_in_if.sink                          i_in_ch,
    svrd_out_if.source                       o_out_ch,
    input  logic                             i_cfg_we,
    input  logic [svrd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [svrd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import svrd_pkg::*;

    localparam int PB       = PHASE_BITS;
    localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int DW       = PB + 17;
    localparam int CNT_W    = $clog2(DW + 1);
    localparam logic [31:0] PEAK      = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [63:0] OUT_ROUND = 64'd1 << (SAMPLE_BITS + 14);

    // Sequencer and architectural state
    t_state                    r_state, n_state;
    logic                      r_out_valid;
    logic [FS_W-1:0]           r_fs;
    logic signed [OFS_W-1:0]   r_ofs;
    logic [GAIN_W-1:0]         r_gain;
    logic [PB-1:0]             r_phase;
    logic [PB-1:0]             r_step;
    logic [31:0]               r_nf;
    logic [15:0]               r_amp;
    logic [15:0]               r_rf;
    logic                      r_releasing;
    logic                      r_sounding;

    // Working registers
    logic [63:0]               r_prod;
    logic [NOTE_W-1:0]         r_note;
    logic [VEL_W-1:0]          r_vel;
    logic [BEND_W-1:0]         r_bend;
    logic [30:0]               r_x;
    logic [31:0]               r_t;
    logic signed [33:0]        r_s;
    logic [2:0]                r_k;
    logic [23:0]               r_n;
    logic [23:0]               r_mag;
    logic [31:0]               r_div_f;
    logic [FS_W-1:0]           r_rem;
    logic [DW-1:0]             r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic [SAMPLE_W-1:0]       r_sample;
    logic [SAMPLE_W-1:0]       r_out_sample;
    logic                      r_out_active;
    logic                      r_out_finished;

    // Combinational nets
    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_mul_en;
    logic [31:0]               w_mul_a, w_mul_b;
    logic signed [8:0]         w_note_sum;
    logic [NOTE_W-1:0]         w_note_cl;
    logic [7:0]                w_m;
    logic [3:0]                w_oct;
    logic [3:0]                w_semi;
    logic [47:0]               w_note_v;
    logic [31:0]               w_note_f;
    logic [23:0]               w_amp_n;
    logic [15:0]               w_amp_q0;
    logic [25:0]               w_amp_rem;
    logic [15:0]               w_amp_q;
    logic [2:0]                w_seg;
    logic [31:0]               w_bdiff;
    logic [31:0]               w_ratio;
    logic [31:0]               w_bent;
    logic [FS_W-1:0]           w_fs_eff;
    logic [DW-1:0]             w_dividend;
    logic [FS_W:0]             w_rem_sh;
    logic                      w_qbit;
    logic [IDX_BITS-1:0]       w_idx;
    logic [IDX_BITS:0]         w_r_raw;
    logic [IDX_BITS:0]         w_r;
    logic                      w_neg;
    logic [31:0]               w_t1;
    logic [7:0]                w_tdiv;
    logic [39:0]               w_tqd;
    logic [39:0]               w_trem;
    logic [31:0]               w_tq;
    logic [30:0]               w_s_cl;
    logic [15:0]               w_level;
    logic [16:0]               w_rounded;
    logic [SAMPLE_W-1:0]       w_sample;
    logic [15:0]               w_rf_new;
    logic                      w_fin;
    logic                      w_act;

    assign w_in_acc   = i_in_ch.valid && i_in_ch.ready;
    assign w_out_free = !r_out_valid || o_out_ch.ready;

    // Note clamp and note-to-frequency conversion
    assign w_note_sum = $signed({2'b00, i_in_ch.note_number}) + 9'(r_ofs);
    always_comb begin
        if (w_note_sum < 0) begin
            w_note_cl = '0;
        end else if (w_note_sum > 9'sd127) begin
            w_note_cl = 7'd127;
        end else begin
            w_note_cl = w_note_sum[6:0];
        end
    end
    assign w_m      = 8'(r_note) + 8'd3;
    assign w_oct    = 4'((16'(w_m) * 16'd171) >> 11);
    assign w_semi   = 4'(w_m - 8'(w_oct) * 8'd12);
    assign w_note_v = 48'(semi55(w_semi)) << w_oct;
    assign w_note_f = 32'((w_note_v + 48'd65536) >> 17);

    // Amplitude: (vel * gain * 12 + 317) / 635 via reciprocal and one correction
    assign w_amp_n   = 24'(r_prod[19:0]) * 24'd12 + 24'd317;
    assign w_amp_q0  = r_prod[47:32];
    assign w_amp_rem = 26'(r_n) - 26'(w_amp_q0) * 26'd635;
    assign w_amp_q   = w_amp_q0 + 16'(w_amp_rem >= 26'd635);

    // Pitch bend interpolation
    assign w_seg   = {1'b0, r_bend[13:12]};
    assign w_bdiff = bend_q30(w_seg + 3'd1) - bend_q30(w_seg);
    assign w_ratio = bend_q30(w_seg) + 32'((r_prod + 64'd2048) >> 12);
    assign w_bent  = 32'((r_prod + 64'd536870912) >> 30);

    // Phase step divider: round(f << (PB-16) / fs)
    assign w_fs_eff   = (r_fs == '0) ? FS_W'(1) : r_fs;
    assign w_dividend = (DW'(r_div_f) << (PB - 16)) + DW'(w_fs_eff >> 1);
    assign w_rem_sh   = {r_rem, r_quo[DW-1]};
    assign w_qbit     = (w_rem_sh >= (FS_W + 1)'(w_fs_eff));

    // Sine argument from phase, quarter-wave folding
    assign w_idx   = r_phase[PB-1 -: IDX_BITS];
    assign w_r_raw = (IDX_BITS + 1)'({w_idx[IDX_BITS-3:0], 2'b00});
    assign w_r     = w_idx[IDX_BITS-2] ? (IDX_BITS + 1)'(SINE_TABLE_DEPTH) - w_r_raw : w_r_raw;
    assign w_neg   = w_idx[IDX_BITS-1];

    // Taylor term division by (2k)(2k+1) via reciprocal and one correction
    assign w_t1   = r_prod[61:30];
    assign w_tdiv = taylor_div(r_k);
    assign w_tqd  = 40'(r_prod[63:32]) * 40'(w_tdiv);
    assign w_trem = 40'(r_t) - w_tqd;
    assign w_tq   = r_prod[63:32] + 32'(w_trem >= 40'(w_tdiv));

    // Series clamp and output scaling
    always_comb begin
        if (r_s < 0) begin
            w_s_cl = '0;
        end else if (r_s > 34'sd1073741824) begin
            w_s_cl = 31'd1073741824;
        end else begin
            w_s_cl = r_s[30:0];
        end
    end
    assign w_level = r_releasing ? r_rf : RELEASE_ONE;
    always_comb begin
        logic [63:0] sh;
        sh = (r_prod + OUT_ROUND) >> (SAMPLE_BITS + 15);
        w_rounded = (sh > 64'd32768) ? 17'd32768 : 17'(sh);
        if (w_neg) begin
            w_sample = SAMPLE_W'(17'd0 - w_rounded);
        end else if (w_rounded > 17'd32767) begin
            w_sample = SAMPLE_W'(17'd32767);
        end else begin
            w_sample = SAMPLE_W'(w_rounded);
        end
    end

    // Release step and end-of-note flags
    assign w_rf_new = 16'((r_prod + 64'd32768) >> 16);
    assign w_fin    = r_sounding && r_releasing && (w_rf_new <= RELEASE_FLOOR);
    assign w_act    = r_sounding && !w_fin;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in_ch.opcode)
                        OP_NOTE_ON:  n_state = S_ON_F;
                        OP_BEND:     n_state = r_sounding ? S_BD_A : S_IDLE;
                        OP_TICK:     n_state = r_sounding ? S_TX : S_TREL;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ON_F:     n_state = S_ON_A;
            S_ON_A:     n_state = S_ON_B;
            S_ON_B:     n_state = S_DIV_INIT;
            S_BD_A:     n_state = S_BD_B;
            S_BD_B:     n_state = S_BD_C;
            S_BD_C:     n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV_RUN;
            S_DIV_RUN:  n_state = (r_cnt == CNT_W'(1)) ? S_DIV_END : S_DIV_RUN;
            S_DIV_END:  n_state = S_IDLE;
            S_TX:       n_state = S_TXS;
            S_TXS:      n_state = S_KA;
            S_KA:       n_state = S_KB;
            S_KB:       n_state = S_KC;
            S_KC:       n_state = S_KD;
            S_KD:       n_state = (r_k == 3'd6) ? S_TMAG : S_KA;
            S_TMAG:     n_state = S_TAMP;
            S_TAMP:     n_state = S_TFULL;
            S_TFULL:    n_state = S_TOUT;
            S_TOUT:     n_state = S_TREL;
            S_TREL:     n_state = w_out_free ? S_IDLE : S_TREL;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and multiplier operand select
    always_comb begin
        i_in_ch.ready = (r_state == S_IDLE);
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_ON_F: begin
                w_mul_a = 32'(r_vel);
                w_mul_b = 32'(r_gain);
            end
            S_ON_A: begin
                w_mul_a = 32'(w_amp_n);
                w_mul_b = AMP_RECIP;
            end
            S_BD_A: begin
                w_mul_a = w_bdiff;
                w_mul_b = 32'(r_bend[11:0]);
            end
            S_BD_B: begin
                w_mul_a = r_nf;
                w_mul_b = w_ratio;
            end
            S_TX: begin
                w_mul_a = HALF_PI_Q30;
                w_mul_b = 32'(w_r);
            end
            S_KA: begin
                w_mul_a = r_t;
                w_mul_b = 32'(r_x);
            end
            S_KB: begin
                w_mul_a = w_t1;
                w_mul_b = 32'(r_x);
            end
            S_KC: begin
                w_mul_a = w_t1;
                w_mul_b = taylor_recip(r_k);
            end
            S_TMAG: begin
                w_mul_a = 32'(w_s_cl);
                w_mul_b = PEAK;
            end
            S_TAMP: begin
                w_mul_a = 32'(r_amp);
                w_mul_b = 32'(w_level);
            end
            S_TFULL: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = 32'(r_mag);
            end
            S_TOUT: begin
                w_mul_a = 32'(r_rf);
                w_mul_b = 32'(RELEASE_DECAY);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.sample_out     = r_out_sample;
    assign o_out_ch.voice_active   = r_out_active;
    assign o_out_ch.voice_finished = r_out_finished;

    // Control, configuration and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fs        <= FS_RESET;
            r_ofs       <= '0;
            r_gain      <= GAIN_RESET;
            r_phase     <= '0;
            r_step      <= '0;
            r_nf        <= '0;
            r_amp       <= '0;
            r_rf        <= '0;
            r_releasing <= 1'b0;
            r_sounding  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_RATE: r_fs   <= i_cfg_data;
                    CFG_NOTE_OFFSET: r_ofs  <= i_cfg_data[OFS_W-1:0];
                    CFG_GAIN:        r_gain <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Output register: load a finished sample, or empty on handshake
            if (r_state == S_TREL && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.valid && o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in_ch.opcode == OP_NOTE_OFF) begin
                        if (i_in_ch.allow_release) begin
                            if (r_sounding && !r_releasing) begin
                                r_releasing <= 1'b1;
                                r_rf        <= RELEASE_ONE;
                            end
                        end else begin
                            r_sounding  <= 1'b0;
                            r_releasing <= 1'b0;
                            r_rf        <= '0;
                            r_step      <= '0;
                        end
                    end
                end
                S_ON_F: begin
                    r_nf        <= w_note_f;
                    r_phase     <= '0;
                    r_rf        <= '0;
                    r_releasing <= 1'b0;
                    r_sounding  <= 1'b1;
                end
                S_ON_B:    r_amp  <= w_amp_q;
                S_DIV_END: r_step <= r_quo[PB-1:0];
                S_TREL: begin
                    if (w_out_free && r_sounding) begin
                        r_phase <= r_phase + r_step;
                        if (w_fin) begin
                            r_sounding  <= 1'b0;
                            r_releasing <= 1'b0;
                            r_rf        <= '0;
                            r_step      <= '0;
                        end else if (r_releasing) begin
                            r_rf <= w_rf_new;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath working registers
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_note   <= w_note_cl;
                    r_vel    <= i_in_ch.note_velocity;
                    r_bend   <= i_in_ch.bend_position;
                    r_sample <= '0;
                end
            end
            S_ON_F: r_div_f <= w_note_f;
            S_ON_A: r_n     <= w_amp_n;
            S_BD_C: r_div_f <= w_bent;
            S_DIV_INIT: begin
                r_quo <= w_dividend;
                r_rem <= '0;
                r_cnt <= CNT_W'(DW);
            end
            S_DIV_RUN: begin
                r_rem <= w_qbit ? FS_W'(w_rem_sh - (FS_W + 1)'(w_fs_eff)) : FS_W'(w_rem_sh);
                r_quo <= {r_quo[DW-2:0], w_qbit};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_TXS: begin
                r_x <= 31'(r_prod >> IDX_BITS);
                r_t <= 32'(r_prod >> IDX_BITS);
                r_s <= 34'(r_prod >> IDX_BITS);
                r_k <= 3'd1;
            end
            S_KC: r_t <= w_t1;
            S_KD: begin
                r_t <= w_tq;
                r_s <= r_k[0] ? r_s - $signed({2'b00, w_tq}) : r_s + $signed({2'b00, w_tq});
                r_k <= r_k + 3'd1;
            end
            S_TAMP: r_mag    <= 24'((r_prod + 64'd536870912) >> 30);
            S_TOUT: r_sample <= w_sample;
            S_TREL: begin
                if (w_out_free) begin
                    r_out_sample   <= r_sample;
                    r_out_active   <= w_act;
                    r_out_finished <= w_fin;
                end
            end
            default: ;
        endcase
    end

    // A release always sits above its end threshold
    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_releasing |-> (r_sounding && r_rf > RELEASE_FLOOR))
        else $error("release active with level at or below floor");

    // A finished note is never reported as still sounding
    a_finish_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.voice_finished) |-> !o_out_ch.voice_active)
        else $error("finished and active in the same sample");

    // A silent voice yields a zero sample
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.voice_active && !o_out_ch.voice_finished)
        |-> (o_out_ch.sample_out == '0))
        else $error("nonzero sample from a silent voice");

    // Leaving the result state always fills the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TREL && w_out_free) |=> r_out_valid)
        else $error("tick completed without a result");

endmodule
